// ----- hdl/clamp_sort_dedup_cut_list_top_macros.svh -----
// Assertion macros used by the cut-list back end.
// Expects clk and rst to be visible at the point of use.
`ifndef CLAMP_SORT_DEDUP_CUT_LIST_TOP_MACROS_SVH
`define CLAMP_SORT_DEDUP_CUT_LIST_TOP_MACROS_SVH

// Same-cycle implication: cond implies expr.
`define CSDC_CHECK(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("csdc: check failed");

// Next-cycle implication: cond implies expr.
`define CSDC_CHECK_NEXT(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("csdc: next-cycle check failed");

`endif

// ----- hdl/csdc_pkg.sv -----
// Types, constants and helpers for the cut-list sorter/deduplicator.
// No dependencies; imported by every module of the block.
package csdc_pkg;

  localparam int MAX_CUTS     = 32;
  localparam int VALUE_BITS   = 32;
  localparam int TOL_BITS     = 16;
  localparam int CMP_BITS     = VALUE_BITS + 1;
  localparam int CNT_BITS     = $clog2(MAX_CUTS + 1);
  localparam int CMD_DEPTH    = 4;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(7);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LOWER = 2'd0,
    CFG_UPPER = 2'd1,
    CFG_TOL   = 2'd2
  } cfg_reg_e;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic signed [CMP_BITS-1:0]   wide_t;

  typedef struct packed {
    value_t cut_value;
    logic   has_value;
    logic   list_end;
  } in_item_t;

  typedef struct packed {
    value_t out_value;
    logic   out_last;
    logic   overflowed;
  } out_item_t;

  typedef struct packed {
    value_t              lower_bound;
    value_t              upper_bound;
    logic [TOL_BITS-1:0] tolerance;
  } cfg_t;

  // Classified request handed from front to back.
  typedef struct packed {
    value_t value;
    logic   keep;
    logic   last;
  } cmd_t;

  function automatic wide_t wide_v(value_t v);
    return CMP_BITS'(v);
  endfunction

  function automatic wide_t wide_tol(logic [TOL_BITS-1:0] t);
    return CMP_BITS'(signed'({1'b0, t}));
  endfunction

endpackage

// ----- hdl/csdc_front.sv -----
// Front end: configuration registers and in-range classification of requests.
// Depends on csdc_pkg.
module csdc_front
  import csdc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  value_t                  cfg_data,
  input  logic                    push,
  output logic                    full,
  input  in_item_t                cut_item,
  output cfg_t                    cfg,
  output logic                    cmd_push,
  output cmd_t                    cmd,
  input  logic                    cmd_full
);

  cfg_t  cfg_q;
  wide_t v_w, l_w, u_w, t_w;
  logic  swap, above_l, below_u, above_u, below_l, in_window;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.lower_bound <= '0;
      cfg_q.upper_bound <= '0;
      cfg_q.tolerance   <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOWER: cfg_q.lower_bound <= cfg_data;
        CFG_UPPER: cfg_q.upper_bound <= cfg_data;
        CFG_TOL:   cfg_q.tolerance   <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Both bound orders are tested in parallel; the swap only selects.
  always_comb begin
    v_w       = wide_v(cut_item.cut_value);
    l_w       = wide_v(cfg_q.lower_bound);
    u_w       = wide_v(cfg_q.upper_bound);
    t_w       = wide_tol(cfg_q.tolerance);
    swap      = cfg_q.upper_bound < cfg_q.lower_bound;
    above_l   = v_w > l_w + t_w;
    below_u   = v_w < u_w - t_w;
    above_u   = v_w > u_w + t_w;
    below_l   = v_w < l_w - t_w;
    in_window = swap ? (above_u && below_l) : (above_l && below_u);
  end

  assign full      = cmd_full;
  assign cmd_push  = push && !cmd_full;
  assign cmd.value = cut_item.cut_value;
  assign cmd.keep  = cut_item.has_value && in_window;
  assign cmd.last  = cut_item.list_end;

endmodule

// ----- hdl/csdc_queue.sv -----
// Short request queue between the front end and the sorting back end.
// Depends on csdc_pkg.
module csdc_queue
  import csdc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  localparam int PTR_BITS  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int QCNT_BITS = $clog2(CMD_DEPTH + 1);

  cmd_t                 slots [CMD_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] fill;
  logic                 do_wr, do_rd;

  assign full    = fill == QCNT_BITS'(CMD_DEPTH);
  assign empty   = fill == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  function automatic logic [PTR_BITS-1:0] bump(logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(CMD_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) wr_ptr <= bump(wr_ptr);
      if (do_rd) rd_ptr <= bump(rd_ptr);
      if (do_wr && !do_rd) fill <= fill + 1'b1;
      else if (do_rd && !do_wr) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule

// ----- hdl/csdc_back.sv -----
// Back end: insertion chain of compare-and-shift cells and the merged readout.
// Depends on csdc_pkg and the assertion macro header.
`include "clamp_sort_dedup_cut_list_top_macros.svh"

module csdc_back
  import csdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      cmd_empty,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t result
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LO    = 5'b00010,
    ST_STORE = 5'b00100,
    ST_HI    = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_t;

  state_t                state;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   left;
  logic                  ovf;
  value_t                cells [MAX_CUTS];
  value_t                pend;
  logic                  out_valid;
  out_item_t             out_data;

  value_t                lo, hi;
  logic [MAX_CUTS-1:0]   gt;
  logic                  out_free, ins, drop, skip_st, skip_hi, shift;
  logic                  out_wr;
  out_item_t             out_wr_data;

  // True when a is within tolerance of b, the last kept value.
  function automatic logic near(value_t a, value_t b, logic [TOL_BITS-1:0] t);
    wide_t wa, wb, wt;
    wa = wide_v(a);
    wb = wide_v(b);
    wt = wide_tol(t);
    return (wa <= wb + wt) && (wa >= wb - wt);
  endfunction

  assign lo = (cfg.upper_bound < cfg.lower_bound) ? cfg.upper_bound : cfg.lower_bound;
  assign hi = (cfg.upper_bound < cfg.lower_bound) ? cfg.lower_bound : cfg.upper_bound;

  assign out_free = !out_valid || pop;
  assign cmd_pop  = (state == ST_IDLE) && !cmd_empty;
  assign ins      = cmd_pop && cmd.keep && (count < CNT_BITS'(MAX_CUTS));
  assign drop     = cmd_pop && cmd.keep && (count == CNT_BITS'(MAX_CUTS));
  assign skip_st  = near(cells[0], pend, cfg.tolerance);
  assign skip_hi  = near(hi, pend, cfg.tolerance);
  assign shift    = (state == ST_STORE) && (skip_st || out_free);

  always_comb begin
    out_wr = 1'b0;
    unique case (state)
      ST_STORE: out_wr = out_free && !skip_st;
      ST_HI:    out_wr = out_free && !skip_hi;
      ST_FLUSH: out_wr = out_free;
      default:  out_wr = 1'b0;
    endcase
    out_wr_data.out_value  = pend;
    out_wr_data.out_last   = state == ST_FLUSH;
    out_wr_data.overflowed = ovf;
  end

  // Cell i is occupied below count; gt is monotone over occupied cells.
  for (genvar i = 0; i < MAX_CUTS; i++) begin : g_cell
    assign gt[i] = (CNT_BITS'(i) < count) && (cells[i] > cmd.value);

    always_ff @(posedge clk) begin
      if (shift) begin
        if (i < MAX_CUTS - 1) cells[i] <= cells[(i < MAX_CUTS - 1) ? i + 1 : i];
      end else if (ins) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          cells[i] <= cells[(i > 0) ? i - 1 : 0];
        end else if (gt[i] || CNT_BITS'(i) == count) begin
          cells[i] <= cmd.value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      left      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_wr) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (ins) count <= count + 1'b1;
          if (drop) ovf <= 1'b1;
          if (cmd_pop && cmd.last) state <= ST_LO;
        end
        ST_LO: begin
          left  <= count;
          state <= (count == '0) ? ST_HI : ST_STORE;
        end
        ST_STORE: begin
          if (shift) begin
            left <= left - 1'b1;
            if (left == CNT_BITS'(1)) state <= ST_HI;
          end
        end
        ST_HI: begin
          if (skip_hi || out_free) state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (out_free) begin
            count <= '0;
            ovf   <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // pend holds the last kept value of the current run, not yet emitted.
  always_ff @(posedge clk) begin
    if (out_wr) out_data <= out_wr_data;
    if (state == ST_LO) begin
      pend <= lo;
    end else if (state == ST_STORE && out_free && !skip_st) begin
      pend <= cells[0];
    end else if (state == ST_HI && out_free && !skip_hi) begin
      pend <= hi;
    end
  end

  assign empty  = !out_valid;
  assign result = out_data;

  `CSDC_CHECK(a_ovf_only_when_full, ovf, count == CNT_BITS'(MAX_CUTS))
  `CSDC_CHECK(a_left_in_range, state == ST_STORE, left != '0 && left <= count)
  `CSDC_CHECK_NEXT(a_end_starts_run, cmd_pop && cmd.last, state == ST_LO)
  `CSDC_CHECK(a_no_pop_in_run, state != ST_IDLE, !cmd_pop)

  for (genvar k = 0; k < MAX_CUTS - 1; k++) begin : g_sorted
    `CSDC_CHECK(a_sorted, state == ST_IDLE && CNT_BITS'(k + 1) < count, cells[k] <= cells[k + 1])
  end

endmodule

// ----- hdl/clamp_sort_dedup_cut_list_top.sv -----
// Channel     Handshake              Payload
// cut items   push / full            cut_item   (in_item_t)
// results     pop / empty            result     (out_item_t)
// config      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Outside a readout one item per cycle is classified; kept ones enter the cell chain.
// A list_end item starts a readout (lower bound, cells, upper bound, final
// flush), paced by the single result register; during it no request leaves
// the 4-deep queue, so push sees full once that fills.
// Synchronous reset sets the bounds to 0, tolerance to 7 and empties the store.
// Top level: front end, request queue, sorting back end. Depends on csdc_pkg.
module clamp_sort_dedup_cut_list_top
  import csdc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  in_item_t                cut_item,
  input  logic                    pop,
  output logic                    empty,
  output out_item_t               result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  value_t                  cfg_data
);

  cfg_t cfg;
  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;

  csdc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .cut_item  (cut_item),
    .cfg       (cfg),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .cmd_full  (cmd_full)
  );

  csdc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  csdc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

// ----- tb/sv/tb_clamp_sort_dedup_cut_list_top.sv -----
// Self-checking bench for the cut-list sorter / deduplicator top level.
// Directed table plus random lists against an in-bench predictor; needs csdc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_clamp_sort_dedup_cut_list_top;
  import csdc_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    bit                  new_cfg;
    value_t              lo;
    value_t              hi;
    logic [TOL_BITS-1:0] tol;
    in_item_t            item;
    bit                  typed;
    out_item_t           want;
  } dir_row_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    push = 1'b0;
  logic                    full;
  in_item_t                cut_item = '0;
  logic                    pop = 1'b0;
  logic                    empty;
  out_item_t               result;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_LOWER;
  value_t                  cfg_data = '0;

  // predictor state
  value_t              cfg_lo = '0;
  value_t              cfg_hi = '0;
  logic [TOL_BITS-1:0] cfg_tol = TOL_RESET;
  value_t              cut_store [MAX_CUTS];
  int                  cut_count = 0;
  bit                  cut_ovf = 1'b0;

  out_item_t pending_cuts [$];
  dir_row_t  dir_tab [$];
  int        mismatches = 0;
  int        sent_items = 0;
  bit        calm = 1'b0;

  clamp_sort_dedup_cut_list_top dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cut_item  (cut_item),
    .pop       (pop),
    .empty     (empty),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_clamp_sort_dedup_cut_list_top: done, errors");
    $finish;
  end

  function automatic value_t clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return value_t'(x);
  endfunction

  function automatic void add_row(bit nc, value_t lo, value_t hi, logic [TOL_BITS-1:0] tol,
                                  value_t v, bit h, bit e, bit typed, value_t want_v);
    dir_row_t r;
    r.new_cfg = nc;
    r.lo = lo;
    r.hi = hi;
    r.tol = tol;
    r.item.cut_value = v;
    r.item.has_value = h;
    r.item.list_end = e;
    r.typed = typed;
    r.want.out_value = want_v;
    r.want.out_last = 1'b1;
    r.want.overflowed = 1'b0;
    dir_tab.push_back(r);
  endfunction

  // Insert one accepted item; on list end, build the merged run lo, store..., hi.
  task automatic predict_cut(in_item_t it, bit record);
    longint    lo, hi, tol, v, s, d, prev;
    longint    cands [$];
    out_item_t run [$];
    out_item_t o;
    int        j;
    lo = cfg_lo;
    hi = cfg_hi;
    tol = longint'(cfg_tol);
    if (hi < lo) begin
      s = lo;
      lo = hi;
      hi = s;
    end
    if (it.has_value) begin
      v = it.cut_value;
      if (v > lo + tol && v < hi - tol) begin
        if (cut_count >= MAX_CUTS) begin
          cut_ovf = 1'b1;
        end else begin
          j = cut_count;
          while (j > 0 && longint'(cut_store[j-1]) > v) begin
            cut_store[j] = cut_store[j-1];
            j--;
          end
          cut_store[j] = value_t'(v);
          cut_count++;
        end
      end
    end
    if (it.list_end) begin
      cands.push_back(lo);
      for (int i = 0; i < cut_count; i++) cands.push_back(cut_store[i]);
      cands.push_back(hi);
      prev = 0;
      foreach (cands[k]) begin
        d = cands[k] - prev;
        if (d < 0) d = -d;
        if (k == 0 || d > tol) begin
          o.out_value = value_t'(cands[k]);
          o.out_last = 1'b0;
          o.overflowed = cut_ovf;
          run.push_back(o);
          prev = cands[k];
        end
      end
      run[run.size()-1].out_last = 1'b1;
      if (record) foreach (run[k]) pending_cuts.push_back(run[k]);
      cut_count = 0;
      cut_ovf = 1'b0;
    end
  endtask

  task automatic send_cut(in_item_t it, bit record);
    calm = (sent_items >= 150 && sent_items < 260);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 21) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    cut_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_cut(it, record);
    sent_items++;
  endtask

  // Block must be idle before any register write.
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_cuts.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, value_t d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_bounds(value_t lo, value_t hi, logic [TOL_BITS-1:0] tol);
    write_reg(CFG_LOWER, lo);
    write_reg(CFG_UPPER, hi);
    // upper bits of the tolerance write are don't-care
    write_reg(CFG_TOL, {16'($urandom), tol});
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_lo = lo;
    cfg_hi = hi;
    cfg_tol = tol;
  endtask

  task automatic pick_setting();
    longint lo, hi, t, s;
    int     mode;
    mode = $urandom_range(0, 99);
    if (mode < 45) begin
      lo = longint'($urandom_range(0, 33554432)) - 16777216;
      hi = lo + longint'($urandom_range(0, 8388608));
      t = $urandom_range(0, 64);
    end else if (mode < 60) begin
      lo = -64'sd2147483648;
      hi = 64'sd2147483647;
      case ($urandom_range(0, 2))
        0: t = 0;
        1: t = 65535;
        default: t = $urandom_range(0, 65535);
      endcase
    end else if (mode < 75) begin
      t = $urandom_range(0, 200);
      lo = longint'($urandom_range(0, 2097152)) - 1048576;
      hi = lo + longint'($urandom_range(0, int'(3 * t + 3)));
    end else begin
      lo = longint'(value_t'($urandom));
      hi = longint'(value_t'($urandom));
      t = $urandom_range(0, 65535);
    end
    if ($urandom_range(0, 1)) begin
      s = lo;
      lo = hi;
      hi = s;
    end
    program_bounds(value_t'(lo), value_t'(hi), t[TOL_BITS-1:0]);
  endtask

  function automatic in_item_t random_cut(longint prev, bit inside_only);
    in_item_t it;
    longint   lo, hi, tol, s;
    int       kind;
    lo = cfg_lo;
    hi = cfg_hi;
    tol = longint'(cfg_tol);
    if (hi < lo) begin
      s = lo;
      lo = hi;
      hi = s;
    end
    kind = inside_only ? 0 : $urandom_range(0, 99);
    it.has_value = 1'b1;
    it.list_end = 1'b0;
    if (kind < 60) begin
      if (hi - tol - 1 >= lo + tol + 1)
        it.cut_value = clamp32(lo + tol + 1 +
                       longint'(u64_t'({$urandom, $urandom}) % u64_t'(hi - lo - 2 * tol - 1)));
      else
        it.cut_value = value_t'($urandom);
    end else if (kind < 72) begin
      // near the previous value, to hit the merge boundary
      it.cut_value = clamp32(prev + longint'($urandom_range(0, int'(2 * tol + 4))) - (tol + 2));
    end else if (kind < 82) begin
      it.cut_value = value_t'($urandom);
    end else if (kind < 90) begin
      it.cut_value = clamp32(($urandom_range(0, 1) ? lo + tol : hi - tol) +
                             longint'($urandom_range(0, 4)) - 2);
    end else begin
      it.cut_value = value_t'($urandom);
      it.has_value = 1'b0;
    end
    return it;
  endfunction

  always @(negedge clk) begin
    pop <= calm || ($urandom_range(0, 99) >= 21);
  end

  always @(posedge clk) begin : check_result
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (pending_cuts.size() == 0) begin
        $display("%0t: unexpected result: expected none, got value %0d last %0b ovf %0b",
                 $time, result.out_value, result.out_last, result.overflowed);
        mismatches++;
      end else begin
        want = pending_cuts.pop_front();
        if (result.out_value !== want.out_value) begin
          $display("%0t: out_value expected %0d got %0d", $time, want.out_value,
                   result.out_value);
          mismatches++;
        end
        if (result.out_last !== want.out_last) begin
          $display("%0t: out_last expected %0b got %0b", $time, want.out_last,
                   result.out_last);
          mismatches++;
        end
        if (result.overflowed !== want.overflowed) begin
          $display("%0t: overflowed expected %0b got %0b", $time, want.overflowed,
                   result.overflowed);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t it;
    longint   prev;
    int       len;
    bit       big;

    //       cfg lo            hi             tol      value          has end typed want
    add_row(0, 0,            0,             0,       0,             0, 1, 1, 0);
    add_row(0, 0,            0,             0,       5,             1, 1, 1, 0);
    add_row(0, 0,            0,             0,       32'sh7FFFFFFF, 1, 1, 1, 0);
    add_row(0, 0,            0,             0,       32'sh80000000, 1, 1, 1, 0);
    add_row(1, -655360,      655360,        7,       100,           1, 0, 0, 0);
    add_row(0, 0,            0,             0,       -655353,       1, 0, 0, 0);
    add_row(0, 0,            0,             0,       -655352,       1, 0, 0, 0);
    add_row(0, 0,            0,             0,       655353,        1, 0, 0, 0);
    add_row(0, 0,            0,             0,       655352,        1, 0, 0, 0);
    add_row(0, 0,            0,             0,       104,           1, 0, 0, 0);
    add_row(0, 0,            0,             0,       -200000,       1, 0, 0, 0);
    add_row(0, 0,            0,             0,       32'sh12345678, 0, 0, 0, 0);
    add_row(0, 0,            0,             0,       300000,        1, 0, 0, 0);
    add_row(0, 0,            0,             0,       107,           1, 0, 0, 0);
    add_row(0, 0,            0,             0,       32'shEDCBA987, 0, 1, 0, 0);
    // swapped bounds, zero tolerance
    add_row(1, 327680,       -327680,       0,       -327679,       1, 0, 0, 0);
    add_row(0, 0,            0,             0,       327680,        1, 0, 0, 0);
    add_row(0, 0,            0,             0,       0,             1, 0, 0, 0);
    add_row(0, 0,            0,             0,       0,             1, 1, 0, 0);
    add_row(1, 32'sh80000000, 32'sh7FFFFFFF, 16'hFFFF, 32'sh80010000, 1, 0, 0, 0);
    add_row(0, 0,            0,             0,       32'sh7FFEFFFF, 1, 0, 0, 0);
    add_row(0, 0,            0,             0,       32'sh7FFFFFFF, 1, 0, 0, 0);
    add_row(0, 0,            0,             0,       32'sh80000000, 1, 1, 0, 0);
    // window empty, bounds still apart
    add_row(1, 0,            10,            7,       5,             1, 1, 0, 0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].new_cfg) begin
        settle();
        program_bounds(dir_tab[r].lo, dir_tab[r].hi, dir_tab[r].tol);
      end
      send_cut(dir_tab[r].item, !dir_tab[r].typed);
      if (dir_tab[r].typed) pending_cuts.push_back(dir_tab[r].want);
    end

    while (sent_items < 410) begin
      settle();
      pick_setting();
      repeat ($urandom_range(1, 4)) begin
        big = ($urandom_range(0, 99) < 15);
        len = big ? $urandom_range(33, 40) : $urandom_range(1, 12);
        prev = cfg_lo;
        for (int k = 0; k < len; k++) begin
          it = random_cut(prev, big);
          it.list_end = (k == len - 1);
          if (k == len - 1 && $urandom_range(0, 99) < 30) it.has_value = 1'b0;
          if (it.has_value) prev = it.cut_value;
          send_cut(it, 1'b1);
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("tb_clamp_sort_dedup_cut_list_top: done, clean");
    end else begin
      $display("tb_clamp_sort_dedup_cut_list_top: done, errors");
    end
    $finish;
  end

endmodule
